FILE: sv/sorted_unique_insert_set_core_assert.svh
// Assertion macros for the sorted unique insert set core.
`ifndef SORTED_UNIQUE_INSERT_SET_CORE_ASSERT_SVH
`define SORTED_UNIQUE_INSERT_SET_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while arst_n is low
`define SUI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sui assertion failed");
// next-cycle implication, clocked on clk, off while arst_n is low
`define SUI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sui assertion failed");
`else
`define SUI_ASSERT_IMP(lbl, ante, cons)
`define SUI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: sv/sui_pkg.sv
// Package with types, codes and defaults of the sorted unique insert set.
`timescale 1ns / 1ps
`default_nettype none
package sui_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned VALUE_W      = 32;
	localparam int unsigned STATUS_W     = 3;
	localparam int unsigned OCC_W        = 5;

	// input operations
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DUMP   = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	// cell commands
	localparam logic [1:0] CMD_HOLD   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_SHIFT  = 2'd2;

	typedef struct packed {
		logic [1:0]                 code;
		logic signed [VALUE_W-1:0]  value;
	} sui_cmd_t;

	// what one cell shows its neighbors and the controller
	typedef struct packed {
		logic                       valid;
		logic                       lt;
		logic                       eq;
		logic signed [VALUE_W-1:0]  value;
	} sui_link_t;

endpackage
`default_nettype wire

FILE: sv/sui_in_if.sv
// Input channel interface: valid/ready handshake with op and value.
`timescale 1ns / 1ps
`default_nettype none
interface sui_in_if;
	import sui_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      op;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

FILE: sv/sui_out_if.sv
// Result channel interface: valid/ready handshake with status, element, last, occupancy.
`timescale 1ns / 1ps
`default_nettype none
interface sui_out_if;
	import sui_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] element;
	logic                      last;
	logic [OCC_W-1:0]          occupancy;

	modport source (output valid, output status, output element, output last,
		output occupancy, input ready);
	modport sink (input valid, input status, input element, input last,
		input occupancy, output ready);
endinterface
`default_nettype wire

FILE: sv/sui_cell.sv
// One cell of the ordered chain: holds one entry, inserts or shifts on command.
`timescale 1ns / 1ps
`default_nettype none
module sui_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sui_pkg::sui_cmd_t cmd,
	input  sui_pkg::sui_link_t left,
	input  sui_pkg::sui_link_t right,
	output sui_pkg::sui_link_t here
);
	import sui_pkg::*;

	logic                      valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      valid_d;
	logic signed [VALUE_W-1:0] value_d;
	logic                      lt;

	assign lt = valid_q && ($signed(value_q) < $signed(cmd.value));

	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		unique case (cmd.code)
			CMD_HOLD: begin
			end
			CMD_INSERT: begin
				// smaller entries stay; the first larger slot takes the new value
				if (!lt) begin
					valid_d = left.valid;
					value_d = left.lt ? cmd.value : left.value;
				end
			end
			CMD_SHIFT: begin
				valid_d = right.valid;
				value_d = right.value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign here.valid = valid_q;
	assign here.lt    = lt;
	assign here.eq    = valid_q && (value_q == cmd.value);
	assign here.value = value_q;
endmodule
`default_nettype wire

FILE: sv/sorted_unique_insert_set_core.sv
// Insert: result word in the cycle after acceptance; one per cycle while not stalled.
// Dump of n entries: n listed words, one per cycle while not stalled, the first from
// the dump state; an empty dump gives one word in the cycle after. No item is taken
// while a dump streams. Speed is set by the cell chain: all cells compare and shift
// in the same cycle. Reset clears cell valid bits, the count and any pending word.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_unique_insert_set_core_assert.svh"
module sorted_unique_insert_set_core #(
	parameter int unsigned CAPACITY = sui_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sui_in_if.sink      req,
	sui_out_if.source   rsp
);
	import sui_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// controller states
	localparam logic FSM_IDLE = 1'b0;
	localparam logic FSM_DUMP = 1'b1;

	logic          state_q;
	logic [CW-1:0] count_q;

	// result word register
	logic                      rsp_valid_q;
	logic [STATUS_W-1:0]       rsp_status_q;
	logic signed [VALUE_W-1:0] rsp_element_q;
	logic                      rsp_last_q;
	logic [OCC_W-1:0]          rsp_occ_q;

	sui_cmd_t          cmd;
	sui_link_t         links [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	logic [CAPACITY-1:0] eq_vec;

	logic slot_free;
	logic acc;
	logic dump_emit;
	logic dup;
	logic full;
	logic do_insert;

	// the result register may be refilled when empty or being drained this cycle
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == FSM_IDLE) && slot_free;
	assign acc       = req.valid && req.ready;
	assign dump_emit = (state_q == FSM_DUMP) && slot_free;

	assign dup       = |eq_vec;
	assign full      = (count_q == CW'(CAPACITY));
	assign do_insert = acc && (req.op == OP_INSERT) && !dup && !full;

	// broadcast one command to every cell
	always_comb begin
		cmd.value = req.value;
		if (do_insert) begin
			cmd.code = CMD_INSERT;
		end else if (dump_emit) begin
			cmd.code = CMD_SHIFT;
		end else begin
			cmd.code = CMD_HOLD;
		end
	end

	// cell chain: left neighbor feeds inserts, right neighbor feeds dumps
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sui_link_t left_l;
		sui_link_t right_l;

		if (i == 0) begin : g_head
			// head boundary acts as a valid entry smaller than anything
			assign left_l = sui_link_t'{valid: 1'b1, lt: 1'b1, eq: 1'b0, value: '0};
		end else begin : g_body
			assign left_l = links[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			// tail boundary shifts in an empty slot
			assign right_l = sui_link_t'{valid: 1'b0, lt: 1'b0, eq: 1'b0, value: '0};
		end else begin : g_mid
			assign right_l = links[i+1];
		end

		sui_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (left_l),
			.right  (right_l),
			.here   (links[i])
		);

		assign valid_vec[i] = links[i].valid;
		assign eq_vec[i]    = links[i].eq;
	end

	// controller: idle takes items, dump streams the head cell out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				FSM_IDLE: begin
					if (do_insert) begin
						count_q <= count_q + CW'(1);
					end else if (acc && (req.op == OP_DUMP) && (count_q != '0)) begin
						state_q <= FSM_DUMP;
					end
				end
				FSM_DUMP: begin
					if (dump_emit) begin
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							state_q <= FSM_IDLE;
						end
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// result valid: set on a new word, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((acc && ((req.op == OP_INSERT) || (count_q == '0))) || dump_emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (dump_emit) begin
			rsp_status_q  <= ST_LISTED;
			rsp_element_q <= links[0].value;
			rsp_last_q    <= (count_q == CW'(1));
			rsp_occ_q     <= '0;
		end else if (acc) begin
			rsp_element_q <= '0;
			rsp_last_q    <= 1'b1;
			if (req.op == OP_DUMP) begin
				// only an empty dump reaches here with a word to give
				rsp_status_q <= ST_EMPTY;
				rsp_occ_q    <= '0;
			end else if (dup) begin
				rsp_status_q <= ST_DUPLICATE;
				rsp_occ_q    <= OCC_W'(count_q);
			end else if (full) begin
				rsp_status_q <= ST_FULL;
				rsp_occ_q    <= OCC_W'(count_q);
			end else begin
				rsp_status_q <= ST_INSERTED;
				rsp_occ_q    <= OCC_W'(count_q + CW'(1));
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.element   = rsp_element_q;
	assign rsp.last      = rsp_last_q;
	assign rsp.occupancy = rsp_occ_q;

	// the cells' valid bits always agree with the entry count
	`SUI_ASSERT_IMP(a_count_matches_cells, 1'b1, ($countones(valid_vec) == int'(count_q)))
	// an accepted item always leaves a pending word or a running dump
	`SUI_ASSERT_NXT(a_accept_gives_work, acc, (rsp.valid || (state_q == FSM_DUMP)))
	// the final listed word returns the controller to idle with an empty set
	`SUI_ASSERT_NXT(a_dump_ends_empty, (dump_emit && (count_q == CW'(1))),
		((state_q == FSM_IDLE) && (count_q == '0)))
	// a full set never grows
	`SUI_ASSERT_NXT(a_full_holds, (acc && full), (count_q == CW'(CAPACITY)))
endmodule
`default_nettype wire

FILE: test/sorted_unique_insert_set_core_test.sv
// Self-checking bench for the sorted unique insert set core: directed and random insert/dump words.
`timescale 1ns / 1ps
module sorted_unique_insert_set_core_test;
	import sui_pkg::*;

	localparam int unsigned SET_CAP      = CAPACITY_DEF;
	localparam int unsigned RANDOM_ITEMS = 440;
	// after the last expected word, give a stray word time to show up
	localparam int unsigned DRAIN_CYCLES = 20;
	// several times the length of a run where every request word streams a full set
	// against the longest receiver stalls
	localparam int unsigned TIMEOUT_NS   = 20_000_000;
	// cap on printed mismatch lines; every mismatch is still counted
	localparam int unsigned MAX_REPORTS  = 40;

	// one result word as the block should produce it
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] element;
		logic                      last;
		logic [OCC_W-1:0]          occupancy;
	} set_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	sui_in_if  set_req ();
	sui_out_if set_rsp ();

	sorted_unique_insert_set_core #(
		.CAPACITY (SET_CAP)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (set_req),
		.rsp    (set_rsp)
	);

	// shadow copy of the ordered set, ascending, no duplicates
	logic signed [VALUE_W-1:0] set_shadow[$];
	// result words still owed by the block, oldest first
	set_result_t               owed_words[$];

	int unsigned words_sent    = 0;
	int unsigned words_checked = 0;
	int unsigned err_count     = 0;
	int unsigned n_inserted    = 0;
	int unsigned n_duplicate   = 0;
	int unsigned n_full        = 0;
	int unsigned n_listed      = 0;
	int unsigned n_empty       = 0;

	// idle controls: gaps on the request side, stalls on the result side
	bit          gap_on     = 1'b0;
	bit          stall_on   = 1'b0;
	int unsigned stall_left = 0;

	// Pause length: mostly none, often a few cycles, now and then a long one.
	function automatic int unsigned pick_pause(bit enabled);
		int unsigned r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string msg);
		if (err_count < MAX_REPORTS)
			$display("MISMATCH @%0t: %s", $time, msg);
		err_count++;
	endtask

	// Apply one accepted word to the shadow set and queue the words it owes.
	function void apply_to_shadow(logic op, logic signed [VALUE_W-1:0] v);
		int unsigned pos;
		int unsigned n;
		set_result_t w;
		n   = set_shadow.size();
		pos = 0;
		w   = '0;
		if (op == OP_INSERT) begin
			// find the first entry not below v (signed compare)
			while (pos < n && set_shadow[pos] < v)
				pos++;
			w.last = 1'b1;
			if (pos < n && set_shadow[pos] == v) begin
				// duplicate wins over full: set stays as it is
				w.status    = ST_DUPLICATE;
				w.occupancy = OCC_W'(n);
				n_duplicate++;
			end else if (n >= SET_CAP) begin
				w.status    = ST_FULL;
				w.occupancy = OCC_W'(n);
				n_full++;
			end else begin
				set_shadow.insert(pos, v);
				w.status    = ST_INSERTED;
				w.occupancy = OCC_W'(n + 1);
				n_inserted++;
			end
			owed_words.push_back(w);
		end else if (n == 0) begin
			w.status = ST_EMPTY;
			w.last   = 1'b1;
			owed_words.push_back(w);
			n_empty++;
		end else begin
			// stream the set in order, flag the final entry, then clear
			foreach (set_shadow[k]) begin
				w.status    = ST_LISTED;
				w.element   = set_shadow[k];
				w.last      = (k + 1 == n);
				w.occupancy = '0;
				owed_words.push_back(w);
				n_listed++;
			end
			set_shadow.delete();
		end
	endfunction

	// Drive one request word from a falling edge; return at the falling edge after acceptance.
	task automatic send_word(logic op, logic signed [VALUE_W-1:0] v);
		int unsigned gap;
		gap = pick_pause(gap_on);
		if (gap != 0) begin
			set_req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		set_req.op    = op;
		set_req.value = v;
		set_req.valid = 1'b1;
		// hold the word until the block takes it
		do
			@(posedge clk);
		while (set_req.ready !== 1'b1);
		apply_to_shadow(op, v);
		words_sent++;
		@(negedge clk);
	endtask

	// Pick an insert value: a narrow band for frequent duplicates, or the wide range,
	// stored values and the two ends of the signed range.
	function automatic logic signed [VALUE_W-1:0] pick_value(bit narrow);
		int unsigned r;
		if (narrow)
			return $urandom_range(0, 12) - 6;
		r = $urandom_range(0, 9);
		if (r < 2 && set_shadow.size() != 0)
			return set_shadow[$urandom_range(0, set_shadow.size() - 1)];
		if (r < 7)
			return $urandom;
		if (r < 8)
			return 32'h7FFF_FFFF - $urandom_range(0, 3);
		return 32'h8000_0000 + $urandom_range(0, 3);
	endfunction

	// Result side: drop ready for random stretches, change it only on falling edges.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			set_rsp.ready = 1'b0;
			stall_left--;
		end else begin
			set_rsp.ready = 1'b1;
			stall_left = pick_pause(stall_on);
		end
	end

	// Compare every accepted result word with the oldest owed word.
	always @(posedge clk) begin : check_rsp
		set_result_t want;
		if (arst_n && set_rsp.valid === 1'b1 && set_rsp.ready === 1'b1) begin
			words_checked++;
			if (owed_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word: status %0d element %0d last %0d occ %0d",
					set_rsp.status, set_rsp.element, set_rsp.last, set_rsp.occupancy));
			end else begin
				want = owed_words.pop_front();
				if (set_rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						set_rsp.status, want.status));
				if (set_rsp.element !== want.element)
					report_mismatch($sformatf("element %0d, want %0d",
						set_rsp.element, want.element));
				if (set_rsp.last !== want.last)
					report_mismatch($sformatf("last %0d, want %0d",
						set_rsp.last, want.last));
				if (set_rsp.occupancy !== want.occupancy)
					report_mismatch($sformatf("occupancy %0d, want %0d",
						set_rsp.occupancy, want.occupancy));
			end
		end
	end

	// A dump right after reset must report the empty set.
	task automatic test_empty_dump();
		gap_on   = 1'b0;
		stall_on = 1'b0;
		send_word(OP_DUMP, '1);
	endtask

	// Both ends of the signed range, zero and +/-1, plus a repeat while not full.
	task automatic test_extremes_and_duplicate();
		gap_on   = 1'b0;
		stall_on = 1'b1;
		send_word(OP_INSERT, 32'sh7FFF_FFFF);
		send_word(OP_INSERT, 32'sh8000_0000);
		send_word(OP_INSERT, 32'sh7FFF_FFFF);
		send_word(OP_INSERT, 0);
		send_word(OP_INSERT, -1);
		send_word(OP_INSERT, 1);
	endtask

	// Fill the set with interleaved values, overflow it, repeat a value while full,
	// then stream all entries and dump the now empty set.
	task automatic test_full_set();
		int k;
		gap_on   = 1'b1;
		stall_on = 1'b1;
		for (k = 1; k <= int'(SET_CAP) - 5; k++)
			send_word(OP_INSERT, (k % 2 != 0) ? k * 100 : -k * 100);
		send_word(OP_INSERT, 77);
		send_word(OP_INSERT, 0);
		send_word(OP_DUMP, 32'h5A5A_A5A5);
		send_word(OP_DUMP, 0);
	endtask

	// Bursts of inserts closed by a dump; some bursts run past capacity,
	// some are empty so that dumps follow dumps.
	task automatic test_random_traffic();
		int unsigned target;
		int unsigned burst_len;
		int unsigned r;
		bit          narrow;
		target = words_sent + RANDOM_ITEMS;
		while (words_sent < target) begin
			gap_on   = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			narrow   = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 9);
			if (r < 1)
				burst_len = 0;
			else if (r < 8)
				burst_len = $urandom_range(1, 12);
			else
				burst_len = $urandom_range(SET_CAP - 2, SET_CAP + 8);
			repeat (burst_len)
				send_word(OP_INSERT, pick_value(narrow));
			send_word(OP_DUMP, $urandom);
		end
	endtask

	initial begin
		set_req.valid = 1'b0;
		set_req.op    = OP_INSERT;
		set_req.value = '0;
		set_rsp.ready = 1'b0;
		// hold reset, then release it away from the rising edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_dump();
		test_extremes_and_duplicate();
		test_full_set();
		test_random_traffic();
		set_req.valid = 1'b0;

		// wait for every owed word, then watch a little longer for strays
		while (owed_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d request words, checked %0d result words.", words_sent, words_checked);
		$display("Inserted %0d, duplicate %0d, dropped full %0d, listed %0d, empty dumps %0d.",
			n_inserted, n_duplicate, n_full, n_listed, n_empty);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout: %0d result words still owed", owed_words.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
